// ===== hdl/rsd_pkg.sv =====
// shared types and constants for the run-length sprite decoder
`default_nettype none

package rsd_pkg;

  // queue between decoder front and output back
  localparam int QDEPTH = 4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // configuration register indexes
  localparam logic [2:0] REG_START_X      = 3'd0;
  localparam logic [2:0] REG_START_Y      = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_WIDE_OUTPUT  = 3'd4;

  localparam logic [7:0] CMD_NEWLINE_ALT = 8'h80;

  typedef struct packed {
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        wide_output;
  } cfg_t;

  // one queued result, coordinates travel beside it
  typedef struct packed {
    logic        kind;
    logic        run_last;
    logic [15:0] word;
  } rec_t;

endpackage

`default_nettype wire

// ===== hdl/rsd_cfg.sv =====
// configuration registers behind the apb-style port
`default_nettype none

module rsd_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output rsd_pkg::cfg_t    cfg
);
  import rsd_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x      <= 12'd0;
      cfg.start_y      <= 12'd0;
      cfg.frame_width  <= 13'd4096;
      cfg.frame_height <= 13'd4096;
      cfg.wide_output  <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_START_X:      cfg.start_x      <= pwdata[11:0];
        REG_START_Y:      cfg.start_y      <= pwdata[11:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[12:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[12:0];
        REG_WIDE_OUTPUT:  cfg.wide_output  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_X:      prdata = {20'd0, cfg.start_x};
      REG_START_Y:      prdata = {20'd0, cfg.start_y};
      REG_FRAME_WIDTH:  prdata = {19'd0, cfg.frame_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, cfg.frame_height};
      REG_WIDE_OUTPUT:  prdata = {31'd0, cfg.wide_output};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rsd_front.sv =====
// byte decoder: header, commands and pixel bytes into result records
`default_nettype none

module rsd_front #(
  parameter int COORD_BITS = 12,
  parameter int W          = 18 + 2 * COORD_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rsd_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    stream_byte,
  input  wire logic          q_room,
  output logic               push0,
  output logic               push1,
  output logic [W-1:0]       data0,
  output logic [W-1:0]       data1
);
  import rsd_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CMD    = 2'd1;
  localparam logic [1:0] PH_LO     = 2'd2;
  localparam logic [1:0] PH_HI     = 2'd3;

  logic [1:0]            phase, phase_next;
  logic [3:0]            hcount, hcount_next;
  logic signed [32:0]    remaining, remaining_next;
  logic [COORD_BITS-1:0] column, column_next;
  logic [COORD_BITS-1:0] line_no, line_no_next;
  logic [6:0]            run_left, run_left_next;
  logic [7:0]            low_byte, low_byte_next;

  logic                  accept;
  logic                  is_run;
  logic [8:0]            cost;
  logic signed [32:0]    rem_dec;
  logic signed [32:0]    hdr_size;
  logic                  rem_le0, dec_le0, hdr_le0;
  logic [6:0]            rl_dec;
  rec_t                  pix_rec, done_rec;

  assign in_ready = q_room;
  assign accept   = in_valid & in_ready;

  assign is_run   = stream_byte[7] & (stream_byte[6:0] != 7'd0);
  assign cost     = is_run ? ({1'b0, stream_byte[6:0], 1'b0} + 9'd1) : 9'd1;
  assign rem_dec  = remaining - $signed({24'd0, cost});
  assign hdr_size = {remaining[31], remaining[31:0]};
  assign rem_le0  = remaining[32] | (remaining == 33'sd0);
  assign dec_le0  = rem_dec[32] | (rem_dec == 33'sd0);
  assign hdr_le0  = hdr_size[32] | (hdr_size == 33'sd0);
  assign rl_dec   = run_left - 7'd1;

  assign done_rec = '{kind: KIND_DONE, run_last: 1'b0, word: 16'd0};
  assign pix_rec  = '{kind: KIND_PIXEL, run_last: (rl_dec == 7'd0),
                      word: {stream_byte, low_byte}};

  always_comb begin
    phase_next     = phase;
    hcount_next    = hcount;
    remaining_next = remaining;
    column_next    = column;
    line_no_next   = line_no;
    run_left_next  = run_left;
    low_byte_next  = low_byte;
    push0          = 1'b0;
    push1          = 1'b0;
    data0          = {done_rec, {(2*COORD_BITS){1'b0}}};
    data1          = {done_rec, {(2*COORD_BITS){1'b0}}};
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (hcount < 4'd4) begin
            remaining_next[{hcount[1:0], 3'b000} +: 8] = stream_byte;
          end
          if (hcount == 4'd15) begin
            hcount_next   = 4'd0;
            column_next   = COORD_BITS'(cfg.start_x);
            line_no_next  = COORD_BITS'(cfg.start_y);
            run_left_next = 7'd0;
            if (hdr_le0) begin
              push0          = 1'b1;
              remaining_next = 33'sd0;
            end else begin
              remaining_next = hdr_size;
              phase_next     = PH_CMD;
            end
          end else begin
            hcount_next = hcount + 4'd1;
          end
        end
        PH_CMD: begin
          if (is_run) begin
            run_left_next  = stream_byte[6:0];
            remaining_next = rem_dec;
            phase_next     = PH_LO;
          end else begin
            if (stream_byte[6:0] == 7'd0) begin
              // 0x00 or 0x80: new line
              line_no_next = line_no + COORD_BITS'(1);
              column_next  = COORD_BITS'(cfg.start_x);
            end else begin
              column_next = column + COORD_BITS'(stream_byte[6:0]);
            end
            if (dec_le0) begin
              push0          = 1'b1;
              phase_next     = PH_HEADER;
              hcount_next    = 4'd0;
              remaining_next = 33'sd0;
            end else begin
              remaining_next = rem_dec;
            end
          end
        end
        PH_LO: begin
          low_byte_next = stream_byte;
          phase_next    = PH_HI;
        end
        PH_HI: begin
          push0         = 1'b1;
          data0         = {pix_rec, column, line_no};
          run_left_next = rl_dec;
          column_next   = column + COORD_BITS'(1);
          if (rl_dec != 7'd0) begin
            phase_next = PH_LO;
          end else if (rem_le0) begin
            push1          = 1'b1;
            phase_next     = PH_HEADER;
            hcount_next    = 4'd0;
            remaining_next = 33'sd0;
          end else begin
            phase_next = PH_CMD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hcount    <= 4'd0;
      remaining <= 33'sd0;
      column    <= '0;
      line_no   <= '0;
      run_left  <= 7'd0;
      low_byte  <= 8'd0;
    end else begin
      phase     <= phase_next;
      hcount    <= hcount_next;
      remaining <= remaining_next;
      column    <= column_next;
      line_no   <= line_no_next;
      run_left  <= run_left_next;
      low_byte  <= low_byte_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rsd_queue.sv =====
// small result queue, up to two pushes and one pop per cycle
`default_nettype none

module rsd_queue #(
  parameter int W = 42
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push0,
  input  wire logic         push1,
  input  wire logic [W-1:0] data0,
  input  wire logic [W-1:0] data1,
  output logic              room,
  output logic              q_valid,
  output logic [W-1:0]      q_data,
  input  wire logic         pop
);
  import rsd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     mem [QDEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_push;
  logic             do_pop;

  assign q_valid = (count != '0);
  assign q_data  = mem[rp];
  assign do_pop  = pop & q_valid;
  assign room    = (count <= CNT_W'(QDEPTH - 2));
  assign n_push  = CNT_W'(push0) + CNT_W'(push1);

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wp] <= data0;
    end
    if (push1) begin
      mem[wp + PTR_W'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PTR_W'(n_push);
      if (do_pop) begin
        rp <= rp + PTR_W'(1);
      end
      count <= count + n_push - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rsd_back.sv =====
// output stage: colour expansion, frame test and result register
`default_nettype none

module rsd_back #(
  parameter int COORD_BITS = 12,
  parameter int W          = 18 + 2 * COORD_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rsd_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire logic [W-1:0]  q_data,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               kind,
  output logic [11:0]        pix_x,
  output logic [11:0]        pix_y,
  output logic [31:0]        colour,
  output logic               outside,
  output logic               run_last
);
  import rsd_pkg::*;

  localparam int CMP_W = (COORD_BITS > 13) ? COORD_BITS : 13;

  rec_t                  rec;
  logic [COORD_BITS-1:0] x, y;
  logic [31:0]           col_c;
  logic                  out_c;

  assign rec = q_data[W-1 -: $bits(rec_t)];
  assign x   = q_data[2*COORD_BITS-1 -: COORD_BITS];
  assign y   = q_data[COORD_BITS-1:0];
  assign pop = q_valid & (~out_valid | out_ready);

  always_comb begin
    if (rec.kind == KIND_DONE) begin
      col_c = 32'd0;
    end else if (cfg.wide_output) begin
      col_c = {ALPHA_OPAQUE, rec.word[15:11], 3'b000, rec.word[10:5], 2'b00,
               rec.word[4:0], 3'b000};
    end else begin
      col_c = {16'd0, rec.word};
    end
    out_c = (rec.kind == KIND_PIXEL) &&
            ((CMP_W'(x) >= CMP_W'(cfg.frame_width)) ||
             (CMP_W'(y) >= CMP_W'(cfg.frame_height)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind     <= rec.kind;
      pix_x    <= 12'(x);
      pix_y    <= 12'(y);
      colour   <= col_c;
      outside  <= out_c;
      run_last <= rec.run_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rle_rgb565_sprite_decoder_unit.sv =====
// top level of the run-length rgb565 sprite layer decoder
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | stream_byte
//   output   | out_valid/ out_ready | kind, pix_x, pix_y, colour, outside, run_last
//   config   | psel/penable/pready  | paddr, pwdata, prdata
//
// one byte per cycle; each byte is decoded in the cycle it is taken and its
// 0, 1 or 2 results enter a 4-entry queue. results leave through a registered
// output stage at one per cycle while out_ready allows.
// input stalls only when the queue cannot take two more results.
// reset is synchronous and puts the decoder back at the start of a header.
`default_nettype none

module rle_rgb565_sprite_decoder_unit #(
  parameter int COORD_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [11:0]      pix_x,
  output logic [11:0]      pix_y,
  output logic [31:0]      colour,
  output logic             outside,
  output logic             run_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rsd_pkg::*;

  localparam int W = $bits(rec_t) + 2 * COORD_BITS;

  cfg_t         cfg;
  logic         q_room, push0, push1, q_valid, pop;
  logic [W-1:0] data0, data1, q_data;

  rsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsd_front #(.COORD_BITS(COORD_BITS), .W(W)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .q_room      (q_room),
    .push0       (push0),
    .push1       (push1),
    .data0       (data0),
    .data1       (data1)
  );

  rsd_queue #(.W(W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push0   (push0),
    .push1   (push1),
    .data0   (data0),
    .data1   (data1),
    .room    (q_room),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  rsd_back #(.COORD_BITS(COORD_BITS), .W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .colour    (colour),
    .outside   (outside),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

// ===== dv/tb_rle_rgb565_sprite_decoder_unit.sv =====
// testbench for the run-length rgb565 sprite layer decoder: sends layers and checks each result
`default_nettype none

module tb_rle_rgb565_sprite_decoder_unit;
  import rsd_pkg::*;

  localparam logic [7:0] CMD_NEWLINE = 8'h00;
  localparam logic [7:0] RUN_FLAG    = 8'h80;
  localparam logic [7:0] SKIP_MAX    = 8'h7F;
  localparam int DRAIN_GUARD = 20000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {ST_HEADER, ST_CMD, ST_LO, ST_HI} dec_state_e;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] colour;
    logic        outside;
    logic        run_last;
  } pixel_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [11:0] pix_x;
  logic [11:0] pix_y;
  logic [31:0] colour;
  logic        outside;
  logic        run_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rle_rgb565_sprite_decoder_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .colour      (colour),
    .outside     (outside),
    .run_last    (run_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // shadow copy of the registers
  logic [11:0] cfg_start_x;
  logic [11:0] cfg_start_y;
  logic [12:0] cfg_frame_width;
  logic [12:0] cfg_frame_height;
  logic        cfg_wide;

  // decoder state as predicted
  dec_state_e         dec_phase;
  logic [3:0]         hdr_count;
  logic signed [32:0] remaining;
  logic [11:0]        column;
  logic [11:0]        line_no;
  logic [6:0]         run_left;
  logic [7:0]         low_byte;

  pixel_result_t pending_results[$];
  int err_count;
  int items_sent;
  int in_gap_max;
  int ready_gap_max;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL rle_rgb565_sprite_decoder_unit");
    $finish;
  end

  task automatic note_failure(input string msg, input pixel_result_t exp_r,
                              input pixel_result_t got_r);
    err_count++;
    if (err_count <= 10)
      $display({"%s: exp kind=%0d x=%0d y=%0d colour=%h out=%0d last=%0d",
                " | got kind=%0d x=%0d y=%0d colour=%h out=%0d last=%0d"},
               msg, exp_r.kind, exp_r.x, exp_r.y, exp_r.colour, exp_r.outside,
               exp_r.run_last, got_r.kind, got_r.x, got_r.y, got_r.colour,
               got_r.outside, got_r.run_last);
  endtask

  task automatic push_done();
    pixel_result_t r;
    r = '0;
    r.kind = KIND_DONE;
    pending_results.push_back(r);
  endtask

  // advance the predicted decoder by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] raw;
    logic [15:0] w;
    pixel_result_t r;
    case (dec_phase)
      ST_HEADER: begin
        if (hdr_count < 4) begin
          raw = remaining[31:0] | (32'(b) << (8 * hdr_count));
          remaining = {1'b0, raw};
        end
        if (hdr_count == 4'd15) begin
          raw = remaining[31:0];
          remaining = {raw[31], raw};
          hdr_count = '0;
          column = cfg_start_x;
          line_no = cfg_start_y;
          run_left = '0;
          if (remaining <= 0) begin
            push_done();
            remaining = '0;
          end else begin
            dec_phase = ST_CMD;
          end
        end else begin
          hdr_count = hdr_count + 4'd1;
        end
      end
      ST_CMD: begin
        remaining = remaining - 33'sd1;
        if (b == CMD_NEWLINE || b == CMD_NEWLINE_ALT) begin
          line_no = line_no + 12'd1;
          column = cfg_start_x;
        end else if (b > RUN_FLAG) begin
          run_left = b[6:0];
          remaining = remaining - $signed({25'd0, run_left, 1'b0});
          dec_phase = ST_LO;
        end else begin
          column = column + 12'(b);
        end
        // a run command never ends the layer before its pixels
        if (dec_phase == ST_CMD && remaining <= 0) begin
          push_done();
          dec_phase = ST_HEADER;
          hdr_count = '0;
          remaining = '0;
        end
      end
      ST_LO: begin
        low_byte = b;
        dec_phase = ST_HI;
      end
      default: begin
        w = {b, low_byte};
        run_left = run_left - 7'd1;
        r.kind = KIND_PIXEL;
        r.x = column;
        r.y = line_no;
        r.colour = cfg_wide ? {ALPHA_OPAQUE, w[15:11], 3'b000, w[10:5], 2'b00,
                               w[4:0], 3'b000}
                            : {16'h0000, w};
        r.outside = ({1'b0, column} >= cfg_frame_width) ||
                    ({1'b0, line_no} >= cfg_frame_height);
        r.run_last = (run_left == 7'd0);
        pending_results.push_back(r);
        column = column + 12'd1;
        if (!r.run_last) begin
          dec_phase = ST_LO;
        end else if (remaining <= 0) begin
          push_done();
          dec_phase = ST_HEADER;
          hdr_count = '0;
          remaining = '0;
        end else begin
          dec_phase = ST_CMD;
        end
      end
    endcase
  endtask

  // one input transaction; in_valid stays high afterwards so a following
  // byte with no gap goes out back to back
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    decode_byte(b);
  endtask

  task automatic send_header(input logic [31:0] size, input logic use_fill,
                             input logic [7:0] fill);
    for (int i = 0; i < 16; i++) begin
      if (i < 4) send_byte(size[8*i +: 8]);
      else send_byte(use_fill ? fill : 8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(0, 1) ? CMD_NEWLINE_ALT : CMD_NEWLINE;
    if (r < 35) return SKIP_MAX;
    if (r < 50) return 8'($urandom_range(1, 8));
    if (r < 85) return RUN_FLAG | 8'($urandom_range(1, 4));
    if (r < 87) return RUN_FLAG | 8'($urandom_range(5, 127));
    if (r < 88) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap_max();
    int g;
    g = $urandom_range(0, 2);
    return (g == 0) ? 0 : (g == 1) ? 3 : 16;
  endfunction

  task automatic send_random_layer();
    int pick;
    logic [31:0] size;
    in_gap_max = pick_gap_max();
    ready_gap_max = pick_gap_max();
    pick = $urandom_range(0, 99);
    if (pick < 70) size = 32'($urandom_range(1, 24));
    else if (pick < 85) size = 32'($urandom_range(25, 300));
    else if (pick < 90) size = '0;
    else if (pick < 93) size = '1;
    else size = {1'b1, 31'($urandom)};
    send_header(size, 1'b0, 8'h00);
    while (dec_phase != ST_HEADER) begin
      if (dec_phase == ST_CMD) send_byte(pick_command());
      else send_byte(8'($urandom));
    end
  endtask

  task automatic drain_results();
    int guard;
    pixel_result_t none;
    none = '0;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      note_failure("missing result", pending_results[0], none);
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_START_X:      cfg_start_x = val[11:0];
      REG_START_Y:      cfg_start_y = val[11:0];
      REG_FRAME_WIDTH:  cfg_frame_width = val[12:0];
      REG_FRAME_HEIGHT: cfg_frame_height = val[12:0];
      REG_WIDE_OUTPUT:  cfg_wide = val[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [11:0] sx, input logic [11:0] sy,
                           input logic [12:0] fw, input logic [12:0] fh,
                           input logic wide);
    drain_results();
    reg_write(REG_START_X, 32'(sx));
    reg_write(REG_START_Y, 32'(sy));
    reg_write(REG_FRAME_WIDTH, 32'(fw));
    reg_write(REG_FRAME_HEIGHT, 32'(fh));
    reg_write(REG_WIDE_OUTPUT, 32'(wide));
  endtask

  task automatic run_layers_until(input int target);
    while (items_sent < target) send_random_layer();
  endtask

  // a skip, both newline codes, a two-pixel run whose last pixel ends the
  // layer, then a header with zero size
  task automatic test_directed_layer();
    in_gap_max = 0;
    ready_gap_max = 0;
    send_header(32'd8, 1'b1, 8'hFF);
    send_byte(SKIP_MAX);
    send_byte(CMD_NEWLINE);
    send_byte(CMD_NEWLINE_ALT);
    send_byte(RUN_FLAG | 8'd2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_header(32'd0, 1'b1, 8'h00);
  endtask

  task automatic test_narrow_output();
    set_frame(12'd0, 12'd0, 13'd4096, 13'd4096, 1'b0);
    run_layers_until(items_sent + 250);
  endtask

  task automatic test_coord_wrap();
    set_frame(12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1);
    run_layers_until(items_sent + 250);
  endtask

  task automatic test_tiny_frame();
    set_frame(12'd0, 12'd0, 13'd1, 13'd1, 1'b1);
    run_layers_until(items_sent + 200);
  endtask

  task automatic test_odd_frame_sizes();
    set_frame(12'($urandom), 12'($urandom), 13'd0, 13'd8191, 1'($urandom));
    run_layers_until(items_sent + 100);
    set_frame(12'($urandom_range(0, 16)), 12'($urandom_range(0, 16)), 13'd8191, 13'd0,
              1'b1);
    run_layers_until(items_sent + 100);
  endtask

  task automatic test_random_frames();
    for (int k = 0; k < 4; k++) begin
      set_frame(12'($urandom_range(0, 100)), 12'($urandom_range(0, 40)),
                13'($urandom_range(1, 128)), 13'($urandom_range(1, 64)), 1'($urandom));
      run_layers_until(items_sent + 150);
    end
  endtask

  task automatic test_reset_values();
    set_frame(12'd0, 12'd0, 13'd4096, 13'd4096, 1'b1);
    run_layers_until(items_sent + 110);
  endtask

  initial begin : result_checker
    int stall;
    pixel_result_t got_r;
    pixel_result_t exp_r;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) begin
          got_r = '{kind, pix_x, pix_y, colour, outside, run_last};
          if (pending_results.size() == 0) begin
            note_failure("unexpected result", '0, got_r);
          end else begin
            exp_r = pending_results.pop_front();
            if (got_r !== exp_r) note_failure("result mismatch", exp_r, got_r);
          end
          stall = $urandom_range(0, ready_gap_max);
          if (stall != 0) out_ready <= 1'b0;
        end else if (!out_ready) begin
          if (stall > 0) stall--;
          if (stall == 0) out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    stream_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    items_sent = 0;
    in_gap_max = 0;
    ready_gap_max = 0;
    cfg_start_x = '0;
    cfg_start_y = '0;
    cfg_frame_width = 13'd4096;
    cfg_frame_height = 13'd4096;
    cfg_wide = 1'b1;
    dec_phase = ST_HEADER;
    hdr_count = '0;
    remaining = '0;
    column = '0;
    line_no = '0;
    run_left = '0;
    low_byte = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_layer();
    test_narrow_output();
    test_coord_wrap();
    test_tiny_frame();
    test_odd_frame_sizes();
    test_random_frames();
    test_reset_values();
    drain_results();

    if (err_count == 0) begin
      $display("PASS rle_rgb565_sprite_decoder_unit");
    end else begin
      $display("FAIL rle_rgb565_sprite_decoder_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
